// ----- src/lms_pkg.sv -----
// ----------------------------------------------------------------------------
// lms_pkg
// Shared types and constants for the list merge sorter.
// ----------------------------------------------------------------------------
package lms_pkg;

    localparam int DATA_W        = 32;
    localparam int MAX_ITEMS_DEF = 64;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     last_out;
        logic                     overflow;
    } t_out;

    typedef enum logic [1:0] {
        S_LOAD,
        S_START,
        S_MERGE,
        S_EMIT
    } t_state;

endpackage

// ----- src/lms_ram.sv -----
// ----------------------------------------------------------------------------
// lms_ram
// Generic single-write, dual-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // write-first: a read of the entry being written returns the new data
    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr0)) begin
            o_rdata0 <= i_wdata;
        end else begin
            o_rdata0 <= r_mem[i_raddr0];
        end
        if (i_we && (i_waddr == i_raddr1)) begin
            o_rdata1 <= i_wdata;
        end else begin
            o_rdata1 <= r_mem[i_raddr1];
        end
    end

endmodule

// ----- src/list_merge_sort.sv -----
// ----------------------------------------------------------------------------
// list_merge_sort
// Collects a run of signed integers and returns it in ascending order.
// ----------------------------------------------------------------------------
// Input items are written into store A at one per cycle until an item with
// last set arrives; items beyond MAX_ITEMS are dropped and every result of
// that run then carries overflow. A run of n items is sorted by bottom-up
// merge passes that ping-pong between stores A and B: a setup state S_START,
// then ceil(log2 n) passes over all n items, one merged element per cycle,
// bound by the single compare-and-write per cycle on the two RAMs. Results
// then leave at one per cycle, while i_ready allows, from an output register.
// No input is taken while sorting or emitting, and the next run may start
// loading while the final result waits.
// ----------------------------------------------------------------------------
module list_merge_sort #(
    parameter int MAX_ITEMS = lms_pkg::MAX_ITEMS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  lms_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output lms_pkg::t_out o_data
);

    import lms_pkg::*;

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int SW = CW + 2;

    t_state r_state, n_state;

    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_drop, n_drop;
    logic [CW-1:0] r_w, n_w;
    logic [CW-1:0] r_mid, n_mid;
    logic [CW-1:0] r_hi, n_hi;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] r_e, n_e;
    logic          r_src_b, n_src_b;
    logic          r_ovalid, n_ovalid;
    t_out          r_out, n_out;

    logic                     in_fire;
    logic                     out_load;
    logic                     seg_end;
    logic                     pass_end;
    logic [CW:0]              nxt_w;
    logic [CW-1:0]            k_next;
    logic [CW-1:0]            s_lo, s_w;
    logic [CW-1:0]            s_mid, s_hi;
    logic [SW-1:0]            sum_mid, sum_hi;
    logic                     take_i;
    logic [DATA_W-1:0]        rda0, rda1, rdb0, rdb1;
    logic [DATA_W-1:0]        src0, src1;
    logic [DATA_W-1:0]        mrg_val;
    logic                     wa_en, wb_en;
    logic [AW-1:0]            w_addr;
    logic [DATA_W-1:0]        w_data;
    logic [AW-1:0]            rd_addr0, rd_addr1;

    assign o_ready = (r_state == S_LOAD);
    assign in_fire = i_valid && o_ready;
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    // current source store, both RAMs see the same read addresses
    assign src0 = r_src_b ? rdb0 : rda0;
    assign src1 = r_src_b ? rdb1 : rda1;

    assign take_i  = (r_i < r_mid) &&
                     ((r_j >= r_hi) || ($signed(src0) < $signed(src1)));
    assign mrg_val = take_i ? src0 : src1;
    assign k_next  = r_k + CW'(1);
    assign seg_end  = (k_next == r_hi);
    assign pass_end = seg_end && (r_hi == r_cnt);
    assign nxt_w    = {1'b0, r_w} << 1;
    assign out_load = (r_state == S_EMIT) && (!r_ovalid || i_ready);

    // bounds of the next pair of runs, clamped to the run length
    assign sum_mid = SW'(s_lo) + SW'(s_w);
    assign sum_hi  = sum_mid + SW'(s_w);
    assign s_mid   = (sum_mid > SW'(r_cnt)) ? r_cnt : sum_mid[CW-1:0];
    assign s_hi    = (sum_hi > SW'(r_cnt)) ? r_cnt : sum_hi[CW-1:0];

    always_comb begin
        s_lo = '0;
        s_w  = CW'(1);
        if (r_state == S_MERGE) begin
            if (pass_end) begin
                s_w = nxt_w[CW-1:0];
            end else begin
                s_lo = r_hi;
                s_w  = r_w;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (in_fire && i_data.last) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                if (r_cnt == CW'(1)) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_MERGE;
                end
            end
            S_MERGE: begin
                if (pass_end && (nxt_w >= (CW+1)'(r_cnt))) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_load && (r_e == r_cnt - CW'(1))) begin
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_cnt    = r_cnt;
        n_drop   = r_drop;
        n_w      = r_w;
        n_mid    = r_mid;
        n_hi     = r_hi;
        n_i      = r_i;
        n_j      = r_j;
        n_k      = r_k;
        n_e      = r_e;
        n_src_b  = r_src_b;
        n_ovalid = r_ovalid && !i_ready;
        n_out    = r_out;
        wa_en    = 1'b0;
        wb_en    = 1'b0;
        w_addr   = '0;
        w_data   = '0;
        case (r_state)
            S_LOAD: begin
                if (in_fire) begin
                    if (r_cnt < CW'(MAX_ITEMS)) begin
                        wa_en  = 1'b1;
                        w_addr = r_cnt[AW-1:0];
                        w_data = i_data.value;
                        n_cnt  = r_cnt + CW'(1);
                    end else begin
                        n_drop = 1'b1;
                    end
                end
            end
            S_START: begin
                n_w     = CW'(1);
                n_src_b = 1'b0;
                n_e     = '0;
                n_i     = s_lo;
                n_j     = s_mid;
                n_k     = s_lo;
                n_mid   = s_mid;
                n_hi    = s_hi;
            end
            S_MERGE: begin
                wa_en  = r_src_b;
                wb_en  = !r_src_b;
                w_addr = r_k[AW-1:0];
                w_data = mrg_val;
                n_k    = k_next;
                if (take_i) begin
                    n_i = r_i + CW'(1);
                end else begin
                    n_j = r_j + CW'(1);
                end
                if (seg_end) begin
                    if (pass_end) begin
                        n_src_b = !r_src_b;
                        n_w     = nxt_w[CW-1:0];
                    end
                    n_i   = s_lo;
                    n_j   = s_mid;
                    n_k   = s_lo;
                    n_mid = s_mid;
                    n_hi  = s_hi;
                end
            end
            S_EMIT: begin
                if (out_load) begin
                    n_ovalid           = 1'b1;
                    n_out.sorted_value = src0;
                    n_out.last_out     = (r_e == r_cnt - CW'(1));
                    n_out.overflow     = r_drop;
                    n_e                = r_e + CW'(1);
                    if (r_e == r_cnt - CW'(1)) begin
                        n_e    = '0;
                        n_cnt  = '0;
                        n_drop = 1'b0;
                    end
                end
            end
            default: begin
                n_ovalid = r_ovalid && !i_ready;
            end
        endcase
    end

    // addresses follow the next-cycle indices so read data lines up
    assign rd_addr0 = (n_state == S_EMIT) ? n_e[AW-1:0] : n_i[AW-1:0];
    assign rd_addr1 = n_j[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_cnt    <= '0;
            r_drop   <= 1'b0;
            r_w      <= CW'(1);
            r_mid    <= '0;
            r_hi     <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_e      <= '0;
            r_src_b  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_drop   <= n_drop;
            r_w      <= n_w;
            r_mid    <= n_mid;
            r_hi     <= n_hi;
            r_i      <= n_i;
            r_j      <= n_j;
            r_k      <= n_k;
            r_e      <= n_e;
            r_src_b  <= n_src_b;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    lms_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ITEMS)
    ) u_store_a (
        .i_clk    (i_clk),
        .i_we     (wa_en),
        .i_waddr  (w_addr),
        .i_wdata  (w_data),
        .i_raddr0 (rd_addr0),
        .i_raddr1 (rd_addr1),
        .o_rdata0 (rda0),
        .o_rdata1 (rda1)
    );

    lms_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ITEMS)
    ) u_store_b (
        .i_clk    (i_clk),
        .i_we     (wb_en),
        .i_waddr  (w_addr),
        .i_wdata  (w_data),
        .i_raddr0 (rd_addr0),
        .i_raddr1 (rd_addr1),
        .o_rdata0 (rdb0),
        .o_rdata1 (rdb1)
    );

endmodule

// ----- dv/lms_sort_checker.sv -----
// ----------------------------------------------------------------------------
// lms_sort_checker
// Predicts each sorted run from the input transfers and checks every result.
// ----------------------------------------------------------------------------
// Elements of the open run are kept in ascending order as they arrive, and
// elements past capacity only set the dropped flag. The closing element
// releases the whole run into the queue of expected results. Each result
// transfer is compared field by field with the oldest expected entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module lms_sort_checker #(
    parameter int MAX_ITEMS = lms_pkg::MAX_ITEMS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  lms_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  lms_pkg::t_out i_out_data,
    output int            o_fail_count,
    output int            o_pending
);
    import lms_pkg::*;

    // open run, kept in ascending order
    logic signed [DATA_W-1:0] run_vals [MAX_ITEMS];
    logic [6:0]               run_len;
    logic                     run_dropped;
    t_out                     sorted_q [$];

    task automatic take_element(input t_in item);
        int   pos;
        t_out res;
        pos = run_len;
        if (run_len < MAX_ITEMS) begin
            while (pos > 0 && run_vals[pos-1] > item.value) begin
                run_vals[pos] = run_vals[pos-1];
                pos--;
            end
            run_vals[pos] = item.value;
            run_len++;
        end else begin
            run_dropped = 1'b1;
        end
        if (item.last) begin
            for (int k = 0; k < run_len; k++) begin
                res.sorted_value = run_vals[k];
                res.last_out     = (k == run_len - 1);
                res.overflow     = run_dropped;
                sorted_q.push_back(res);
            end
            run_len     = '0;
            run_dropped = 1'b0;
        end
    endtask

    task automatic check_result(input t_out got);
        t_out want;
        if (sorted_q.size() == 0) begin
            if (o_fail_count < 10)
                $display("%0t: result with none expected: value %0d last %0b ovf %0b",
                         $realtime, got.sorted_value, got.last_out, got.overflow);
            o_fail_count++;
        end else begin
            want = sorted_q.pop_front();
            if (got.sorted_value !== want.sorted_value ||
                got.last_out !== want.last_out ||
                got.overflow !== want.overflow) begin
                if (o_fail_count < 10)
                    $display({"%0t: mismatch: exp value %0d last %0b ovf %0b,",
                              " got value %0d last %0b ovf %0b"},
                             $realtime, want.sorted_value, want.last_out, want.overflow,
                             got.sorted_value, got.last_out, got.overflow);
                o_fail_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            run_len      = '0;
            run_dropped  = 1'b0;
            o_fail_count = 0;
            sorted_q.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                take_element(i_in_data);
            if (i_out_valid && i_out_ready)
                check_result(i_out_data);
        end
        o_pending = sorted_q.size();
    end

endmodule

// ----- dv/tb_list_merge_sort.sv -----
// ----------------------------------------------------------------------------
// tb_list_merge_sort
// Stimulus and verdict for the list merge sorter.
// ----------------------------------------------------------------------------
// A short directed set covers single-element runs, extreme values, ties and
// presorted or reversed runs. Random runs follow: a full-capacity run, a run
// that overflows with its closing element dropped, then mostly short runs
// with the odd long one. Both channels idle at random, with bursts of no
// idling. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_list_merge_sort;
    import lms_pkg::*;

    localparam int N_MAX        = MAX_ITEMS_DEF;
    localparam int RANDOM_ITEMS = 210;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 100;

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef enum int {
        VAL_WIDE,
        VAL_NARROW,
        VAL_EDGE
    } t_val_mix;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_ready;
    t_in   i_data;
    logic  o_valid;
    logic  i_ready;
    t_out  o_data;

    int    fail_count;
    int    pending;
    int    idle_cycles = 0;
    int    items_sent  = 0;
    logic  burst_in    = 1'b0;

    list_merge_sort #(
        .MAX_ITEMS (N_MAX)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    lms_sort_checker #(
        .MAX_ITEMS (N_MAX)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_data    (i_data),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_data   (o_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // no transfer on either side for too long means the block is stuck
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("list_merge_sort verification failed");
            $finish;
        end
    end

    function automatic logic signed [DATA_W-1:0] pick_value(input t_val_mix mix);
        logic signed [DATA_W-1:0] v;
        case (mix)
            VAL_WIDE: v = $urandom;
            VAL_NARROW: begin
                v = $urandom_range(0, 8);
                v = v - 4;
            end
            default: begin
                case ($urandom_range(0, 4))
                    0: v = VAL_MIN;
                    1: v = VAL_MAX;
                    2: v = 0;
                    3: v = -1;
                    default: v = 1;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic push_elem(input logic signed [DATA_W-1:0] value, input logic last);
        int gap;
        gap = burst_in ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= {value, last};
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
    endtask

    task automatic send_run(input int len, input t_val_mix mix);
        burst_in = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < len; k++)
            push_elem(pick_value(mix), k == len - 1);
    endtask

    // result side: random stalls, with stretches of none
    initial begin : result_sink
        int   stall;
        logic burst;
        burst = 1'b0;
        i_ready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 15) == 0)
                burst = ~burst;
            stall = burst ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin : stimulus
        int       random_start;
        int       len;
        t_val_mix mix;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single-element runs at the extremes and at zero
        push_elem(VAL_MIN, 1'b1);
        push_elem(VAL_MAX, 1'b1);
        push_elem(0, 1'b1);
        // two elements, out of order
        push_elem(VAL_MAX, 1'b0);
        push_elem(VAL_MIN, 1'b1);
        // ties, sign boundary and extremes mixed
        push_elem(5, 1'b0);
        push_elem(-3, 1'b0);
        push_elem(5, 1'b0);
        push_elem(0, 1'b0);
        push_elem(-1, 1'b0);
        push_elem(VAL_MIN, 1'b0);
        push_elem(VAL_MAX, 1'b0);
        push_elem(-3, 1'b1);
        // already ascending, then descending
        for (int k = -2; k <= 1; k++)
            push_elem(k, k == 1);
        for (int k = 4; k >= 0; k--)
            push_elem(k, k == 0);

        random_start = items_sent;
        // exactly full, then overflow with the closing element dropped
        send_run(N_MAX, VAL_WIDE);
        send_run(N_MAX + 2, VAL_NARROW);
        while (items_sent - random_start < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(N_MAX - 1, N_MAX + 4);
            else
                len = $urandom_range(1, 12);
            case ($urandom_range(0, 3))
                0:       mix = VAL_NARROW;
                1:       mix = VAL_EDGE;
                default: mix = VAL_WIDE;
            endcase
            send_run(len, mix);
        end
        i_valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("list_merge_sort verification clean");
        else
            $display("list_merge_sort verification failed");
        $finish;
    end

endmodule
